// ----- rtl/core/ikc_pkg.sv -----
package ikc_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight) + 1;
  localparam int WidthW    = ColW + 1;
  localparam int InRowW    = RowW + 1;
  localparam int BaseW     = InRowW + WidthW + 1;
  localparam int NumTaps   = 9;
  localparam int TapIdxW   = $clog2(NumTaps);
  localparam int AccW      = 29;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 48;

  localparam logic [1:0] EDGE_CLAMP   = 2'd0;
  localparam logic [1:0] EDGE_BORDER  = 2'd1;
  localparam logic [1:0] EDGE_CONFINE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_KERNEL_ROW0  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_ROW1  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_ROW2  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EDGE_MODE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BORDER_COLOR = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HAS_ALPHA    = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_of_frame;
  } out_beat_t;

  typedef struct packed {
    logic [NumTaps-1:0][31:0] win;
    logic [RowW-1:0]          orow;
    logic [ColW-1:0]          ocol;
    logic                     last;
  } ikc_item_t;

  typedef struct packed {
    logic [NumTaps-1:0][31:0] taps;
    logic                     copy;
    logic [31:0]              center;
    logic                     last;
    logic [3:0][AccW-1:0]     acc;
  } ikc_lane_t;

endpackage

// ----- rtl/core/ikc_front.sv -----
module ikc_front import ikc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  in_beat_t            in_data,
  output logic                in_ready,
  input  logic                cfg_we,
  input  logic [WidthW-1:0]   width,
  input  logic [RowW-1:0]     height,
  input  logic                down_ready,
  output logic                item_valid,
  output ikc_item_t           item
);

  logic [31:0] upper_mem [MaxWidth];
  logic [31:0] middle_mem [MaxWidth];
  logic [31:0] rd_u;
  logic [31:0] rd_m;

  logic [ColW-1:0]    ic;
  logic [InRowW-1:0]  ir;
  logic [ColW-1:0]    oc;
  logic [RowW-1:0]    orow;
  logic [BaseW-1:0]   in_base;
  logic [BaseW-1:0]   out_base;
  logic               stale;
  logic [NumTaps-1:0][31:0] win;
  logic [NumTaps-1:0][31:0] win_next;

  logic               drain;
  logic               go;
  logic               emit;
  logic               last;
  logic               col_wrap;
  logic               ocol_wrap;
  logic [WidthW-1:0]  ic_inc;
  logic [WidthW-1:0]  oc_inc;
  logic [31:0]        pix;
  logic [ColW-1:0]    raddr;
  logic [BaseW:0]     inpos;
  logic [BaseW:0]     out_lim;
  logic               stage_free;

  assign stage_free = !item_valid || down_ready;
  assign in_ready   = stage_free && !stale;
  assign drain      = ir >= InRowW'(height);
  assign go         = in_valid && in_ready && !(in_data.mode && !drain);
  assign pix        = drain ? 32'd0 : {in_data.in_alpha, in_data.in_blue,
                                       in_data.in_green, in_data.in_red};
  assign ic_inc     = WidthW'(ic) + WidthW'(1);
  assign oc_inc     = WidthW'(oc) + WidthW'(1);
  assign col_wrap   = ic_inc >= width;
  assign ocol_wrap  = oc_inc >= width;
  assign inpos      = (BaseW+1)'(in_base) + (BaseW+1)'(ic);
  assign out_lim    = (BaseW+1)'(out_base) + (BaseW+1)'(oc) + (BaseW+1)'(width)
                      + (BaseW+1)'(1);
  assign emit       = inpos >= out_lim;
  assign last       = ((InRowW'(orow) + InRowW'(1)) >= InRowW'(height)) && ocol_wrap;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = rd_u;
    win_next[5] = rd_m;
    win_next[8] = pix;
  end

  always_comb begin
    if (!go) begin
      raddr = ic;
    end else if ((emit && last) || col_wrap) begin
      raddr = '0;
    end else begin
      raddr = ic_inc[ColW-1:0];
    end
  end

  // Line stores: one write and one prefetch read of the next column per cycle while a beat is taken.
  always_ff @(posedge clk) begin
    if (go) begin
      upper_mem[ic]  <= rd_m;
      middle_mem[ic] <= pix;
    end
    if (go && raddr == ic) begin
      rd_u <= rd_m;
      rd_m <= pix;
    end else begin
      rd_u <= upper_mem[raddr];
      rd_m <= middle_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic         <= '0;
      ir         <= '0;
      oc         <= '0;
      orow       <= '0;
      in_base    <= '0;
      out_base   <= '0;
      stale      <= 1'b0;
      win        <= '0;
      item_valid <= 1'b0;
    end else begin
      stale <= cfg_we;
      if (stale) begin
        in_base  <= BaseW'(BaseW'(ir) * BaseW'(width));
        out_base <= BaseW'(BaseW'(orow) * BaseW'(width));
      end
      if (stage_free) begin
        item_valid <= go && emit;
        item       <= '{win: win_next, orow: orow, ocol: oc, last: last};
      end
      if (go) begin
        if (emit && last) begin
          ic       <= '0;
          ir       <= '0;
          oc       <= '0;
          orow     <= '0;
          in_base  <= '0;
          out_base <= '0;
          win      <= '0;
        end else begin
          win <= win_next;
          if (col_wrap) begin
            ic      <= '0;
            ir      <= ir + InRowW'(1);
            in_base <= in_base + BaseW'(width);
          end else begin
            ic <= ic_inc[ColW-1:0];
          end
          if (emit) begin
            if (ocol_wrap) begin
              oc       <= '0;
              orow     <= orow + RowW'(1);
              out_base <= out_base + BaseW'(width);
            end else begin
              oc <= oc_inc[ColW-1:0];
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/ikc_mac_cell.sv -----
module ikc_mac_cell import ikc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  ikc_lane_t   up_lane,
  output logic        up_ready,
  input  logic [31:0] tap,
  input  logic [15:0] coef,
  input  logic        down_ready,
  output logic        valid,
  output ikc_lane_t   lane
);

  logic signed [24:0] prod [4];
  ikc_lane_t          lane_next;

  assign up_ready = !valid || down_ready;

  always_comb begin
    lane_next = up_lane;
    for (int ch = 0; ch < 4; ch++) begin
      prod[ch] = $signed({1'b0, tap[8*ch +: 8]}) * $signed(coef);
      lane_next.acc[ch] = up_lane.acc[ch] + {{(AccW-25){prod[ch][24]}}, prod[ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      lane <= lane_next;
    end
  end

endmodule

// ----- rtl/core/image_kernel_convolution_3x3.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data  (in_beat_t)
// out     | output    | out_valid / out_ready | out_data (out_beat_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel or flush beat is taken per cycle while in_ready is high; the line
// store port and the window shift then do one column per cycle. A result
// passes through the window register with the edge rule, nine MAC cells and
// the output register after the beat that completes its window is taken. The
// cycle after a configuration write takes no input while the frame position
// bases are recomputed. Reset is synchronous and needs no clearing pass. A
// stalled output only blocks input once every stage behind it is full.
module image_kernel_convolution_3x3 import ikc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_beat_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_beat_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [2:0][47:0]   kernel_row;
  logic [1:0]         edge_mode;
  logic [31:0]        border_color;
  logic [WidthW-1:0]  image_width;
  logic [RowW-1:0]    image_height;
  logic               has_alpha;
  logic [WidthW-1:0]  eff_w;
  logic [RowW-1:0]    eff_h;
  logic               cfg_we;

  logic               item_valid;
  ikc_item_t          item;

  logic signed [15:0] ys [3];
  logic signed [15:0] xs [3];
  logic signed [15:0] yc [3];
  logic signed [15:0] xc [3];
  logic signed [15:0] ydif [3];
  logic signed [15:0] xdif [3];
  logic [1:0]         ry [3];
  logic [1:0]         rx [3];
  logic               y_out [3];
  logic               x_out [3];
  logic [TapIdxW-1:0] idx;
  logic signed [15:0] hm1;
  logic signed [15:0] wm1;
  ikc_lane_t          lane0;

  logic [NumTaps:0]   cell_valid;
  logic [NumTaps:0]   cell_ready;
  ikc_lane_t          cell_lane [NumTaps+1];

  logic               out_free;
  logic signed [AccW-1:0] sum;
  logic [31:0]        result;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row   <= '0;
      edge_mode    <= EDGE_CLAMP;
      border_color <= '0;
      image_width  <= WidthW'(MaxWidth);
      image_height <= RowW'(1);
      has_alpha    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_ROW0:  kernel_row[0] <= cfg_data[47:0];
        REG_KERNEL_ROW1:  kernel_row[1] <= cfg_data[47:0];
        REG_KERNEL_ROW2:  kernel_row[2] <= cfg_data[47:0];
        REG_EDGE_MODE:    edge_mode     <= cfg_data[1:0];
        REG_BORDER_COLOR: border_color  <= cfg_data[31:0];
        REG_IMAGE_WIDTH:  image_width   <= cfg_data[WidthW-1:0];
        REG_IMAGE_HEIGHT: image_height  <= cfg_data[RowW-1:0];
        REG_HAS_ALPHA:    has_alpha     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = WidthW'(1);
    end else if (image_width > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = RowW'(1);
    end else if (image_height > RowW'(MaxHeight)) begin
      eff_h = RowW'(MaxHeight);
    end else begin
      eff_h = image_height;
    end
  end

  ikc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .cfg_we     (cfg_we),
    .width      (eff_w),
    .height     (eff_h),
    .down_ready (cell_ready[0]),
    .item_valid (item_valid),
    .item       (item)
  );

  // Edge rule: pick the nine taps the kernel sees for this output position.
  always_comb begin
    hm1 = $signed(16'(eff_h)) - 16'sd1;
    wm1 = $signed(16'(eff_w)) - 16'sd1;
    for (int d = 0; d < 3; d++) begin
      ys[d]    = $signed(16'(item.orow) + 16'(d) - 16'd1);
      xs[d]    = $signed(16'(item.ocol) + 16'(d) - 16'd1);
      y_out[d] = (ys[d] < 0) || (ys[d] > hm1);
      x_out[d] = (xs[d] < 0) || (xs[d] > wm1);
      yc[d]    = (ys[d] < 0) ? 16'sd0 : ((ys[d] > hm1) ? hm1 : ys[d]);
      xc[d]    = (xs[d] < 0) ? 16'sd0 : ((xs[d] > wm1) ? wm1 : xs[d]);
      ydif[d]  = yc[d] - $signed(16'(item.orow)) + 16'sd1;
      xdif[d]  = xc[d] - $signed(16'(item.ocol)) + 16'sd1;
      ry[d]    = (ydif[d] < 0) ? 2'd0 : ((ydif[d] > 16'sd2) ? 2'd2 : ydif[d][1:0]);
      rx[d]    = (xdif[d] < 0) ? 2'd0 : ((xdif[d] > 16'sd2) ? 2'd2 : xdif[d][1:0]);
    end
    lane0        = '0;
    lane0.center = item.win[4];
    lane0.last   = item.last;
    lane0.copy   = (edge_mode == EDGE_CONFINE) &&
                   ((item.orow <= RowW'(1)) || (item.ocol <= ColW'(1)) ||
                    ((InRowW'(item.orow) + InRowW'(2)) >= InRowW'(eff_h)) ||
                    ((WidthW'(item.ocol) + WidthW'(2)) >= eff_w));
    idx = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (edge_mode == EDGE_BORDER) begin
          lane0.taps[r*3+c] = (y_out[r] || x_out[c]) ? border_color : item.win[r*3+c];
        end else begin
          idx = TapIdxW'(ry[r]) * TapIdxW'(3) + TapIdxW'(rx[c]);
          lane0.taps[r*3+c] = item.win[idx];
        end
      end
    end
  end

  assign cell_valid[0] = item_valid;
  assign cell_lane[0]  = lane0;

  for (genvar k = 0; k < NumTaps; k++) begin : g_cell
    ikc_mac_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (cell_valid[k]),
      .up_lane    (cell_lane[k]),
      .up_ready   (cell_ready[k]),
      .tap        (cell_lane[k].taps[k]),
      .coef       (kernel_row[k/3][16*(k%3) +: 16]),
      .down_ready (cell_ready[k+1]),
      .valid      (cell_valid[k+1]),
      .lane       (cell_lane[k+1])
    );
  end

  assign out_free              = !out_valid || out_ready;
  assign cell_ready[NumTaps]   = out_free;

  always_comb begin
    result = '0;
    sum    = '0;
    for (int ch = 0; ch < 4; ch++) begin
      sum = $signed(cell_lane[NumTaps].acc[ch]);
      if (sum <= 0) begin
        result[8*ch +: 8] = 8'd0;
      end else if (sum[AccW-1:8] > (AccW-8)'(255)) begin
        result[8*ch +: 8] = 8'd255;
      end else begin
        result[8*ch +: 8] = sum[15:8];
      end
    end
    if (cell_lane[NumTaps].copy) begin
      result = cell_lane[NumTaps].center;
    end
    if (!has_alpha) begin
      result[31:24] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= cell_valid[NumTaps];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= '{out_red:       result[7:0],
                    out_green:     result[15:8],
                    out_blue:      result[23:16],
                    out_alpha:     result[31:24],
                    last_of_frame: cell_lane[NumTaps].last};
    end
  end

endmodule

// ----- rtl/core/ikc_checker.sv -----
module ikc_checker import ikc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output beat changed while stalled.");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("Input taken in the cycle after a configuration write.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output beat shown right after reset.");

endmodule

bind image_kernel_convolution_3x3 ikc_checker u_ikc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ----- bench/tb.sv -----
module tb;
  import ikc_pkg::*;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam int   STALL_LIMIT = 6000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_beat_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  image_kernel_convolution_3x3 i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_beat_t  pending_beats[$];
  out_beat_t expected_pixels[$];
  int        mismatches;
  int        idle_cycles;
  int        send_gap;
  int        stall_gap;
  int        pushed_beats;
  logic      in_fire;

  // Shadow of the configuration registers.
  logic [47:0] kernel_rows[3];
  logic [1:0]  edge_sel;
  logic [31:0] border_rgba;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic        alpha_on;

  // Shadow of the line stores, window and frame position.
  logic [31:0] upper_line[MaxWidth];
  logic [31:0] middle_line[MaxWidth];
  logic [31:0] window_taps[9];
  int          in_col, in_row, out_col, out_row;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int frame_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int frame_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MaxHeight) h = MaxHeight;
    return h;
  endfunction

  function automatic logic [31:0] edge_tap(int dy, int dx, int w, int h);
    int y, x, ry, rx;
    y = out_row + dy;
    x = out_col + dx;
    if (edge_sel == EDGE_BORDER) begin
      if (y < 0 || x < 0 || y >= h || x >= w) return border_rgba;
      return window_taps[(dy + 1) * 3 + dx + 1];
    end
    y = (y < 0) ? 0 : (y > h - 1) ? h - 1 : y;
    x = (x < 0) ? 0 : (x > w - 1) ? w - 1 : x;
    ry = y - out_row + 1;
    rx = x - out_col + 1;
    ry = (ry < 0) ? 0 : (ry > 2) ? 2 : ry;
    rx = (rx < 0) ? 0 : (rx > 2) ? 2 : rx;
    return window_taps[ry * 3 + rx];
  endfunction

  task automatic convolve_beat(input in_beat_t b);
    int          w, h, ic, sum, v;
    logic        drain, last;
    logic [31:0] pix, u, m, rgba, tp;
    longint      inpos, outpos;
    out_beat_t   res;
    w = frame_width();
    h = frame_height();
    drain = in_row >= h;
    if (b.mode == MODE_FLUSH && !drain) return;
    pix = drain ? 32'd0 : {b.in_alpha, b.in_blue, b.in_green, b.in_red};
    ic = in_col;
    u = upper_line[ic];
    m = middle_line[ic];
    upper_line[ic] = m;
    middle_line[ic] = pix;
    for (int r = 0; r < 3; r++) begin
      window_taps[r * 3] = window_taps[r * 3 + 1];
      window_taps[r * 3 + 1] = window_taps[r * 3 + 2];
    end
    window_taps[2] = u;
    window_taps[5] = m;
    window_taps[8] = pix;
    inpos = longint'(in_row) * w + in_col;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    outpos = longint'(out_row) * w + out_col;
    if (inpos < outpos + w + 1) return;
    rgba = '0;
    if (edge_sel == EDGE_CONFINE &&
        (out_row <= 1 || out_col <= 1 || out_row >= h - 2 || out_col >= w - 2)) begin
      rgba = window_taps[4];
    end else begin
      for (int ch = 0; ch < 4; ch++) begin
        sum = 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++) begin
            tp = edge_tap(r - 1, c - 1, w, h);
            sum += int'(tp[8 * ch +: 8]) *
                   int'($signed(kernel_rows[r][16 * c +: 16]));
          end
        v = (sum <= 0) ? 0 : sum >>> 8;
        if (v > 255) v = 255;
        rgba[8 * ch +: 8] = v[7:0];
      end
    end
    if (!alpha_on) rgba[31:24] = '0;
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res = '{out_red: rgba[7:0], out_green: rgba[15:8], out_blue: rgba[23:16],
            out_alpha: rgba[31:24], last_of_frame: last};
    expected_pixels.push_back(res);
    if (last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      for (int t = 0; t < 9; t++) window_taps[t] = '0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (in_valid && in_ready) convolve_beat(in_data);
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", out_data);
        end else begin
          if (out_data !== expected_pixels[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_pixels[0], out_data);
          end
          void'(expected_pixels.pop_front());
        end
      end
    end
  end

  // Input driver and output stall generator.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_gap <= pick_gap();
      end
    end
  end

  task automatic drain_and_settle();
    while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KERNEL_ROW0:  kernel_rows[0] = val;
      REG_KERNEL_ROW1:  kernel_rows[1] = val;
      REG_KERNEL_ROW2:  kernel_rows[2] = val;
      REG_EDGE_MODE:    edge_sel = val[1:0];
      REG_BORDER_COLOR: border_rgba = val[31:0];
      REG_IMAGE_WIDTH:  width_reg = val[10:0];
      REG_IMAGE_HEIGHT: height_reg = val[12:0];
      default:          alpha_on = val[0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_coef();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h7FFF;
    if (p == 1) return 16'h8000;
    if (p < 4) return 16'($urandom());
    return 16'($signed($urandom_range(0, 640)) - 256);
  endfunction

  task automatic random_kernel();
    for (int r = 0; r < 3; r++)
      write_reg(CfgIdxW'(REG_KERNEL_ROW0 + r), {rand_coef(), rand_coef(), rand_coef()});
  endtask

  function automatic in_beat_t rand_beat(logic md);
    in_beat_t b;
    b = $urandom();
    b.mode = md;
    return b;
  endfunction

  task automatic queue_frame(input bit noisy);
    int w, h;
    w = frame_width();
    h = frame_height();
    for (int p = 0; p < w * h; p++) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        pending_beats.push_back(rand_beat(MODE_FLUSH));
        pushed_beats++;
      end
      pending_beats.push_back(rand_beat(MODE_PIXEL));
      pushed_beats++;
    end
    for (int d = 0; d <= w; d++) begin
      pending_beats.push_back(rand_beat(1'($urandom_range(0, 1))));
      pushed_beats++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KERNEL_ROW0;
    cfg_data = '0;
    mismatches = 0;
    send_gap = 0;
    stall_gap = 0;
    pushed_beats = 0;
    kernel_rows = '{default: '0};
    edge_sel = EDGE_CLAMP;
    border_rgba = '0;
    width_reg = 11'd1024;
    height_reg = 13'd1;
    alpha_on = 1'b1;
    for (int i = 0; i < MaxWidth; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int t = 0; t < 9; t++) window_taps[t] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity kernel on a small frame with saturated pixel values.
    write_reg(REG_KERNEL_ROW1, 48'h0000_0100_0000);
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    pending_beats.push_back('{mode: MODE_PIXEL, in_red: 8'hFF, in_green: 8'h00,
                              in_blue: 8'hFF, in_alpha: 8'h00});
    pending_beats.push_back('{mode: MODE_FLUSH, in_red: 8'h12, in_green: 8'h34,
                              in_blue: 8'h56, in_alpha: 8'h78});
    for (int p = 1; p < 9; p++)
      pending_beats.push_back(p[0] ? in_beat_t'{MODE_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF}
                                   : in_beat_t'{MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    for (int d = 0; d < 4; d++) pending_beats.push_back(rand_beat(d[0]));
    drain_and_settle();

    // Extreme coefficients, border mode and every edge mode on small frames.
    write_reg(REG_KERNEL_ROW0, {16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_KERNEL_ROW2, {16'h8000, 16'h0080, 16'h8000});
    write_reg(REG_BORDER_COLOR, 32'hFFFF_FFFF);
    write_reg(REG_HAS_ALPHA, 1'b0);
    for (int e = 0; e < 4; e++) begin
      write_reg(REG_EDGE_MODE, e[1:0]);
      queue_frame(1'b1);
      drain_and_settle();
    end

    // Zero width and height saturate to one.
    write_reg(REG_HAS_ALPHA, 1'b1);
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    queue_frame(1'b0);
    drain_and_settle();
    write_reg(REG_IMAGE_WIDTH, 11'd12);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    write_reg(REG_EDGE_MODE, EDGE_BORDER);
    write_reg(REG_BORDER_COLOR, 32'h0000_0000);
    queue_frame(1'b0);
    drain_and_settle();

    while (pushed_beats < 1050) begin
      if ($urandom_range(0, 2) == 0) random_kernel();
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_EDGE_MODE, CfgDataW'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_BORDER_COLOR, CfgDataW'($urandom()));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_HAS_ALPHA, CfgDataW'($urandom_range(0, 1)));
      write_reg(REG_IMAGE_WIDTH, CfgDataW'($urandom_range(1, 12)));
      write_reg(REG_IMAGE_HEIGHT, CfgDataW'($urandom_range(1, 8)));
      queue_frame(1'b1);
      if ($urandom_range(0, 2) == 0) begin
        queue_frame(1'b1);
      end
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
